// ----- hdl/periodic_laplacian_sde_step_unit_defines.svh -----
// assertion helpers shared by the step unit modules
`ifndef PERIODIC_LAPLACIAN_SDE_STEP_UNIT_DEFINES_SVH
`define PERIODIC_LAPLACIAN_SDE_STEP_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PLSDE_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("plsde assertion failed");

// next-cycle implication, checked outside reset
`define PLSDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("plsde assertion failed");

`endif

// ----- hdl/plsde_pkg.sv -----
`timescale 1ns / 1ps
package plsde_pkg;

  localparam int IDX_BITS     = 16;
  localparam int NSQ_BITS     = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int WIDE_BITS    = 64;
  localparam int DIGIT_BITS   = 32;

  localparam logic [WIDE_BITS-1:0] WIDE_MAX = {1'b0, {(WIDE_BITS-1){1'b1}}};
  localparam logic [WIDE_BITS-1:0] WIDE_MIN = {1'b1, {(WIDE_BITS-1){1'b0}}};
  localparam logic [IDX_BITS-1:0]  POINTS_RESET = 16'd3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POINTS = 3'd0,
    CFG_GAIN   = 3'd1,
    CFG_DRIFT  = 3'd2,
    CFG_NSCALE = 3'd3,
    CFG_DT     = 3'd4
  } cfg_idx_e;

  // how the array ended: one, two, or three or more points
  typedef enum logic [1:0] {
    K_ONE  = 2'd0,
    K_TWO  = 2'd1,
    K_FULL = 2'd2
  } run_kind_e;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_LO   = 5'b00010,
    M_HI   = 5'b00100,
    M_RND  = 5'b01000,
    M_SAT  = 5'b10000
  } mul_state_e;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LAP   = 10'b0000000010,
    W_LAP   = 10'b0000000100,
    S_GAIN  = 10'b0000001000,
    W_GAIN  = 10'b0000010000,
    S_DRIFT = 10'b0000100000,
    W_NOISE = 10'b0001000000,
    S_DT    = 10'b0010000000,
    W_DT    = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic start;
    logic use_frac;
  } mul_ctl_t;

  // 64-bit signed add, clipped to the signed range
  function automatic logic [WIDE_BITS-1:0] sat_add(input logic [WIDE_BITS-1:0] a,
                                                   input logic [WIDE_BITS-1:0] b);
    logic [WIDE_BITS:0] s;
    s = {a[WIDE_BITS-1], a} + {b[WIDE_BITS-1], b};
    if (s[WIDE_BITS] != s[WIDE_BITS-1]) begin
      sat_add = s[WIDE_BITS] ? WIDE_MIN : WIDE_MAX;
    end else begin
      sat_add = s[WIDE_BITS-1:0];
    end
  endfunction

endpackage

// ----- hdl/plsde_fifo.sv -----
`timescale 1ns / 1ps
`include "periodic_laplacian_sde_step_unit_defines.svh"
module plsde_fifo
  import plsde_pkg::*;
#(
  parameter int WIDTH = 145
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output fifo_stat_t       stat_o
);

  logic [WIDTH-1:0]     mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_q, wptr_d;
  logic [QPTR_BITS-1:0] rptr_q, rptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assign data_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  `PLSDE_ASSERT(a_no_overflow, clk_i, rst_ni, push_i, !stat_o.full)
  `PLSDE_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i, !stat_o.empty)

endmodule

// ----- hdl/plsde_front.sv -----
`timescale 1ns / 1ps
module plsde_front
  import plsde_pkg::*;
#(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic signed [SAMPLE_BITS-1:0]         noise_i,
  input  logic                                  is_last_i,
  input  logic [IDX_BITS-1:0]                   glen_i,
  input  fifo_stat_t                            qstat_i,
  output logic                                  push_o,
  output logic [4*SAMPLE_BITS+IDX_BITS:0]       job_o
);

  logic [SAMPLE_BITS-1:0] first_q, second_q, older_q, newer_q;
  logic [SAMPLE_BITS-1:0] first_nz_q, held_nz_q;
  logic [SAMPLE_BITS-1:0] x_q, xnz_q;
  logic [IDX_BITS-1:0]    pos_q, p_q;
  run_kind_e              kind_q, kind_d;
  logic [1:0]             step_q;
  logic                   pend_q;

  logic                   accept, is_end, str_push, pend_push, step_last;
  logic [IDX_BITS:0]      pos_inc;
  logic [SAMPLE_BITS-1:0] lft, rgt, cen, jnz;
  logic [IDX_BITS-1:0]    jidx;
  logic                   jend;

  assign in_ready_o = !pend_q && !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_inc    = {1'b0, pos_q} + 1'b1;
  assign is_end     = is_last_i || (pos_inc >= {1'b0, glen_i});
  // interior points go out as soon as their right neighbor arrives
  assign str_push   = accept && !is_end && (pos_q >= 16'd2);
  assign pend_push  = pend_q && !qstat_i.full;
  assign push_o     = str_push || pend_push;

  always_comb begin
    if (pos_q == '0) begin
      kind_d = K_ONE;
    end else if (pos_q == 16'd1) begin
      kind_d = K_TWO;
    end else begin
      kind_d = K_FULL;
    end
  end

  always_comb begin
    step_last = 1'b0;
    unique case (kind_q)
      K_ONE:   step_last = 1'b1;
      K_TWO:   step_last = (step_q == 2'd1);
      K_FULL:  step_last = (step_q == 2'd2);
      default: step_last = 1'b1;
    endcase
  end

  // job mux: left, right, centre of the second difference plus noise, index and end flag
  always_comb begin
    lft  = '0;
    rgt  = '0;
    cen  = '0;
    jnz  = xnz_q;
    jidx = '0;
    jend = 1'b0;
    if (pend_q) begin
      unique case (kind_q)
        K_ONE: begin
          jend = 1'b1;
        end
        K_TWO: begin
          if (step_q == 2'd0) begin
            jidx = 16'd1;
          end else begin
            jnz  = first_nz_q;
            jend = 1'b1;
          end
        end
        K_FULL: begin
          case (step_q)
            2'd0: begin
              lft  = older_q;
              rgt  = x_q;
              cen  = newer_q;
              jnz  = held_nz_q;
              jidx = p_q - 1'b1;
            end
            2'd1: begin
              lft  = newer_q;
              rgt  = first_q;
              cen  = x_q;
              jidx = p_q;
            end
            default: begin
              lft  = x_q;
              rgt  = second_q;
              cen  = first_q;
              jnz  = first_nz_q;
              jend = 1'b1;
            end
          endcase
        end
        default: begin
          jend = 1'b1;
        end
      endcase
    end else begin
      lft  = older_q;
      rgt  = sample_i;
      cen  = newer_q;
      jnz  = held_nz_q;
      jidx = pos_q - 1'b1;
    end
  end

  assign job_o = {lft, rgt, cen, jnz, jidx, jend};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= '0;
      second_q   <= '0;
      older_q    <= '0;
      newer_q    <= '0;
      first_nz_q <= '0;
      held_nz_q  <= '0;
      x_q        <= '0;
      xnz_q      <= '0;
      pos_q      <= '0;
      p_q        <= '0;
      kind_q     <= K_ONE;
      step_q     <= '0;
      pend_q     <= 1'b0;
    end else begin
      if (accept) begin
        if (is_end) begin
          // neighbor state stays put; the wrap-around jobs read it
          pend_q <= 1'b1;
          step_q <= '0;
          kind_q <= kind_d;
          x_q    <= sample_i;
          xnz_q  <= noise_i;
          p_q    <= pos_q;
          pos_q  <= '0;
        end else begin
          if (pos_q == '0) begin
            first_q    <= sample_i;
            first_nz_q <= noise_i;
          end else if (pos_q == 16'd1) begin
            second_q <= sample_i;
          end
          older_q   <= newer_q;
          newer_q   <= sample_i;
          held_nz_q <= noise_i;
          pos_q     <= pos_inc[IDX_BITS-1:0];
        end
      end
      if (pend_push) begin
        step_q <= step_q + 1'b1;
        if (step_last) begin
          pend_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/plsde_mul.sv -----
`timescale 1ns / 1ps
`include "periodic_laplacian_sde_step_unit_defines.svh"
module plsde_mul
  import plsde_pkg::*;
#(
  parameter int OPB_BITS  = 33,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mul_ctl_t             ctl_i,
  input  logic [WIDE_BITS-1:0] a_i,
  input  logic [OPB_BITS-1:0]  b_i,
  output logic                 done_o,
  output logic [WIDE_BITS-1:0] res_o
);

  localparam int PROD_BITS = WIDE_BITS + OPB_BITS;
  localparam int PP_BITS   = DIGIT_BITS + OPB_BITS;
  localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

  mul_state_e             state_q, state_d;
  logic                   neg_q, neg_d;
  logic                   frac_q, frac_d;
  logic [WIDE_BITS-1:0]   ua_q, ua_d;
  logic [OPB_BITS-1:0]    ub_q, ub_d;
  logic [PROD_BITS-1:0]   acc_q, acc_d;
  logic [WIDE_BITS-1:0]   res_q, res_d;
  logic                   done_q, done_d;

  logic [DIGIT_BITS-1:0]  digit;
  logic [PP_BITS-1:0]     pp;
  logic [PROD_BITS-1:0]   rnd;
  logic [WIDE_BITS-1:0]   mag, lim;
  logic                   ovf;

  always_comb begin
    // magnitude product, one 32-bit digit of a per cycle
    digit = (state_q == M_HI) ? ua_q[WIDE_BITS-1:DIGIT_BITS] : ua_q[DIGIT_BITS-1:0];
    pp    = {{OPB_BITS{1'b0}}, digit} * {{DIGIT_BITS{1'b0}}, ub_q};
    rnd   = (acc_q + HALF) >> FRAC_BITS;
    mag   = acc_q[WIDE_BITS-1:0];
    lim   = neg_q ? WIDE_MIN : WIDE_MAX;
    ovf   = (|acc_q[PROD_BITS-1:WIDE_BITS]) || (mag > lim);

    state_d = state_q;
    neg_d   = neg_q;
    frac_d  = frac_q;
    ua_d    = ua_q;
    ub_d    = ub_q;
    acc_d   = acc_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      M_IDLE: begin
        if (ctl_i.start) begin
          neg_d   = a_i[WIDE_BITS-1] ^ b_i[OPB_BITS-1];
          frac_d  = ctl_i.use_frac;
          ua_d    = a_i[WIDE_BITS-1] ? ~a_i + WIDE_BITS'(1) : a_i;
          ub_d    = b_i[OPB_BITS-1] ? ~b_i + OPB_BITS'(1) : b_i;
          state_d = M_LO;
        end
      end
      M_LO: begin
        acc_d   = PROD_BITS'(pp);
        state_d = M_HI;
      end
      M_HI: begin
        acc_d   = acc_q + (PROD_BITS'(pp) << DIGIT_BITS);
        state_d = M_RND;
      end
      M_RND: begin
        // round half away from zero on the magnitude
        if (frac_q) begin
          acc_d = rnd;
        end
        state_d = M_SAT;
      end
      M_SAT: begin
        if (ovf) begin
          res_d = neg_q ? WIDE_MIN : WIDE_MAX;
        end else begin
          res_d = neg_q ? ~mag + WIDE_BITS'(1) : mag;
        end
        done_d  = 1'b1;
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    frac_q <= frac_d;
    ua_q   <= ua_d;
    ub_q   <= ub_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `PLSDE_ASSERT(a_start_when_idle, clk_i, rst_ni, ctl_i.start, state_q == M_IDLE)
  `PLSDE_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_q, !done_q)

endmodule

// ----- hdl/plsde_back.sv -----
`timescale 1ns / 1ps
`include "periodic_laplacian_sde_step_unit_defines.svh"
module plsde_back
  import plsde_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS   = 16,
  parameter int OPB_BITS    = 33
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [4*SAMPLE_BITS+IDX_BITS:0] job_i,
  input  fifo_stat_t                      qstat_i,
  output logic                            pop_o,
  input  logic signed [SAMPLE_BITS-1:0]   gain_i,
  input  logic signed [SAMPLE_BITS-1:0]   drift_i,
  input  logic signed [SAMPLE_BITS-1:0]   nscale_i,
  input  logic [SAMPLE_BITS-2:0]          dt_i,
  input  logic [NSQ_BITS-1:0]             nsq_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [IDX_BITS-1:0]             point_index_o,
  output logic signed [SAMPLE_BITS-1:0]   increment_value_o,
  output logic                            run_end_o
);

  localparam int NZ_LO     = IDX_BITS + 1;
  localparam int CEN_LO    = NZ_LO + SAMPLE_BITS;
  localparam int RGT_LO    = CEN_LO + SAMPLE_BITS;
  localparam int LFT_LO    = RGT_LO + SAMPLE_BITS;
  localparam int DIFF_BITS = SAMPLE_BITS + 2;
  localparam int HI_BITS   = WIDE_BITS - SAMPLE_BITS + 1;
  localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  back_state_e                  state_q, state_d;
  logic signed [DIFF_BITS-1:0]  d_q;
  logic signed [SAMPLE_BITS-1:0] nz_q;
  logic [IDX_BITS-1:0]          idx_q;
  logic                         end_q;
  logic [WIDE_BITS-1:0]         h_q, h_d;
  logic                         out_valid_q, out_valid_d;
  logic [IDX_BITS-1:0]          out_idx_q;
  logic [SAMPLE_BITS-1:0]       out_val_q;
  logic                         out_end_q;

  logic signed [SAMPLE_BITS-1:0] lft, rgt, cen;
  logic signed [DIFF_BITS-1:0]  diff;
  mul_ctl_t                     mctl;
  logic [WIDE_BITS-1:0]         ma;
  logic [OPB_BITS-1:0]          mb;
  logic                         mdone;
  logic [WIDE_BITS-1:0]         mres;
  logic                         load_out;
  logic [HI_BITS-1:0]           h_top;
  logic [SAMPLE_BITS-1:0]       sat_val;

  assign lft  = job_i[LFT_LO +: SAMPLE_BITS];
  assign rgt  = job_i[RGT_LO +: SAMPLE_BITS];
  assign cen  = job_i[CEN_LO +: SAMPLE_BITS];
  assign diff = DIFF_BITS'(lft) + DIFF_BITS'(rgt) - (DIFF_BITS'(cen) <<< 1);

  // operand select for the shared multiplier
  always_comb begin
    mctl.start    = 1'b0;
    mctl.use_frac = 1'b1;
    ma            = h_q;
    mb            = '0;
    unique case (state_q)
      S_LAP: begin
        mctl.start    = 1'b1;
        mctl.use_frac = 1'b0;
        ma            = WIDE_BITS'(d_q);
        mb            = OPB_BITS'(nsq_i);
      end
      S_GAIN: begin
        mctl.start = 1'b1;
        mb         = OPB_BITS'(gain_i);
      end
      S_DRIFT: begin
        mctl.start = 1'b1;
        ma         = WIDE_BITS'(nz_q);
        mb         = OPB_BITS'(nscale_i);
      end
      S_DT: begin
        mctl.start = 1'b1;
        mb         = OPB_BITS'(dt_i);
      end
      default: begin
        mctl.start = 1'b0;
      end
    endcase
  end

  plsde_mul #(
    .OPB_BITS (OPB_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mctl),
    .a_i   (ma),
    .b_i   (mb),
    .done_o(mdone),
    .res_o (mres)
  );

  always_comb begin
    state_d  = state_q;
    h_d      = h_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          state_d = S_LAP;
        end
      end
      S_LAP: state_d = W_LAP;
      W_LAP: begin
        if (mdone) begin
          h_d     = mres;
          state_d = mres[WIDE_BITS-1] ? S_GAIN : S_DRIFT;
        end
      end
      S_GAIN: state_d = W_GAIN;
      W_GAIN: begin
        if (mdone) begin
          h_d     = sat_add(h_q, mres);
          state_d = S_DRIFT;
        end
      end
      S_DRIFT: begin
        // drift goes in while the noise product is under way
        h_d     = sat_add(h_q, WIDE_BITS'(drift_i));
        state_d = W_NOISE;
      end
      W_NOISE: begin
        if (mdone) begin
          h_d     = sat_add(h_q, mres);
          state_d = S_DT;
        end
      end
      S_DT: state_d = W_DT;
      W_DT: begin
        if (mdone) begin
          h_d     = mres;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // clip to the output sample range
  always_comb begin
    h_top = h_q[WIDE_BITS-1:SAMPLE_BITS-1];
    if ((&h_top) || !(|h_top)) begin
      sat_val = h_q[SAMPLE_BITS-1:0];
    end else begin
      sat_val = h_q[WIDE_BITS-1] ? OUT_MIN : OUT_MAX;
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || load_out;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      d_q   <= diff;
      nz_q  <= job_i[NZ_LO +: SAMPLE_BITS];
      idx_q <= job_i[IDX_BITS:1];
      end_q <= job_i[0];
    end
    h_q <= h_d;
    if (load_out) begin
      out_idx_q <= idx_q;
      out_val_q <= sat_val;
      out_end_q <= end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign point_index_o     = out_idx_q;
  assign increment_value_o = out_val_q;
  assign run_end_o         = out_end_q;

  `PLSDE_ASSERT(a_done_in_wait, clk_i, rst_ni, mdone, (state_q == W_LAP) || (state_q == W_GAIN) || (state_q == W_NOISE) || (state_q == W_DT))

endmodule

// ----- hdl/periodic_laplacian_sde_step_unit.sv -----
// the back end runs one job at a time and pops the next only after loading the last result;
//   a negative second difference adds the extra gain product to that job
// one shared 32xN digit multiplier: low digit, high digit, round, saturate per product;
//   front: one item per cycle while the 4-entry job queue has room, no wrap job pending
// reset: asynchronous active low; clears control, loads register defaults (points 3, dt 1.0)
`timescale 1ns / 1ps
module periodic_laplacian_sde_step_unit
  import plsde_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]        cfg_data_i,
  // sample stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] noise_i,
  input  logic                          is_last_i,
  // increment stream
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [IDX_BITS-1:0]           point_index_o,
  output logic signed [SAMPLE_BITS-1:0] increment_value_o,
  output logic                          run_end_o
);

  // one job: left, right, centre, noise, index, end flag
  localparam int JOB_BITS = 4 * SAMPLE_BITS + IDX_BITS + 1;
  localparam int DT_BITS  = SAMPLE_BITS - 1;
  // multiplier b operand must hold the unsigned N squared as a signed value
  localparam int OPB_BITS = (SAMPLE_BITS > NSQ_BITS) ? SAMPLE_BITS : NSQ_BITS + 1;
  localparam logic [DT_BITS-1:0] DT_RESET = DT_BITS'(1) << FRAC_BITS;

  // configuration registers
  logic [IDX_BITS-1:0]          points_q;
  logic signed [SAMPLE_BITS-1:0] gain_q;
  logic signed [SAMPLE_BITS-1:0] drift_q;
  logic signed [SAMPLE_BITS-1:0] nscale_q;
  logic [DT_BITS-1:0]           dt_q;
  logic [NSQ_BITS-1:0]          nsq_q;

  logic [IDX_BITS-1:0]          glen;
  logic                         push, pop;
  logic [JOB_BITS-1:0]          job_in, job_out;
  fifo_stat_t                   qstat;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= POINTS_RESET;
      gain_q   <= '0;
      drift_q  <= '0;
      nscale_q <= '0;
      dt_q     <= DT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POINTS: points_q <= cfg_data_i[IDX_BITS-1:0];
        CFG_GAIN:   gain_q   <= cfg_data_i;
        CFG_DRIFT:  drift_q  <= cfg_data_i;
        CFG_NSCALE: nscale_q <= cfg_data_i;
        CFG_DT:     dt_q     <= cfg_data_i[DT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a zero length behaves as a single point
  assign glen = (points_q == '0) ? IDX_BITS'(1) : points_q;

  // N squared, refreshed every cycle; registers are to change only while idle (not enforced)
  always_ff @(posedge clk_i) begin
    nsq_q <= NSQ_BITS'(glen) * NSQ_BITS'(glen);
  end

  // front: keeps the neighbor window, turns each point into a job
  plsde_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_i  (sample_i),
    .noise_i   (noise_i),
    .is_last_i (is_last_i),
    .glen_i    (glen),
    .qstat_i   (qstat),
    .push_o    (push),
    .job_o     (job_in)
  );

  // job queue decouples the window logic from the arithmetic
  plsde_fifo #(
    .WIDTH(JOB_BITS)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(job_in),
    .pop_i (pop),
    .data_o(job_out),
    .stat_o(qstat)
  );

  // back: laplacian scale, gain if that is negative, drift, noise, dt, then clip into the output register
  plsde_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .OPB_BITS   (OPB_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (job_out),
    .qstat_i          (qstat),
    .pop_o            (pop),
    .gain_i           (gain_q),
    .drift_i          (drift_q),
    .nscale_i         (nscale_q),
    .dt_i             (dt_q),
    .nsq_i            (nsq_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .point_index_o    (point_index_o),
    .increment_value_o(increment_value_o),
    .run_end_o        (run_end_o)
  );

endmodule
